// ===== rtl/mh64_pkg.sv =====
// Shared constants, state codes and control structs for the MurmurHash2 64-bit core.
`default_nettype none

package mh64_pkg;

  // Field and register widths
  localparam int WORD_W  = 64;
  localparam int LANE_W  = 32;
  localparam int CNT_W   = 4;
  localparam int LEN_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Mixing constants
  localparam logic [63:0] MUL64    = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MUL32    = 32'h5bd1e995;
  // MUL64 split into halves; the low half equals MUL32
  localparam logic [31:0] MUL64_LO = MUL64[31:0];
  localparam logic [31:0] MUL64_HI = MUL64[63:32];

  localparam int SHIFT64 = 47;
  localparam int SHIFT32 = 24;
  localparam int XMIX_S1 = 18;
  localparam int XMIX_S2 = 22;
  localparam int XMIX_S3 = 17;
  localparam int XMIX_S4 = 19;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANT   = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_SEED,
    ST_A_K1,
    ST_A_K2,
    ST_A_H,
    ST_A_TAIL,
    ST_A_FIN,
    ST_B_K1,
    ST_B_K2,
    ST_B_H,
    ST_B_TAIL,
    ST_B_F1,
    ST_B_F2,
    ST_B_F3,
    ST_B_F4
  } mh64_state_t;

  // Request to and response from the shared multiplier
  typedef struct packed {
    logic start;
    logic wide;
  } mh64_mul_req_t;

  typedef struct packed {
    logic done;
  } mh64_mul_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/mh64_if.sv =====
// Channel interfaces: message words in, hash out, configuration writes.
`default_nettype none

interface mh64_in_if;
  import mh64_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic [CNT_W-1:0]  byte_count;
  logic              first_word;
  logic              last_word;
  logic [LEN_W-1:0]  message_length;

  modport source (output valid, data_word, byte_count, first_word, last_word,
                  message_length, input ready);
  modport sink   (input valid, data_word, byte_count, first_word, last_word,
                  message_length, output ready);
endinterface

interface mh64_out_if;
  import mh64_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

interface mh64_cfg_if;
  import mh64_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [WORD_W-1:0]    write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mh64_mul.sv =====
// Shared multiplier: one 32x32 array, 64-bit low product over three passes or 32-bit in one.
`default_nettype none

module mh64_mul
  import mh64_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mh64_mul_req_t     req,
  input  wire logic [WORD_W-1:0] op_a,
  output      mh64_mul_rsp_t     rsp,
  output      logic [WORD_W-1:0] prod
);

  // Pass codes
  localparam logic [1:0] PH_LO     = 2'd0;
  localparam logic [1:0] PH_CROSS1 = 2'd1;
  localparam logic [1:0] PH_CROSS2 = 2'd2;

  logic [WORD_W-1:0] a_r;
  logic              wide_r;
  logic              run_r, run_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic              done_r, done_nxt;

  logic [LANE_W-1:0] mx, my;
  logic [WORD_W-1:0] m;

  // Operand select per pass: lo*lo, hi*lo, lo*hi
  always_comb begin
    mx = (ph_r == PH_CROSS1) ? a_r[63:32] : a_r[31:0];
    my = (ph_r == PH_CROSS2) ? MUL64_HI : MUL64_LO;
    m  = 64'(mx) * 64'(my);
  end

  // Pass sequencing and accumulation of the upper half
  always_comb begin
    run_nxt  = run_r;
    ph_nxt   = ph_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (req.start) begin
      run_nxt = 1'b1;
      ph_nxt  = PH_LO;
    end else if (run_r) begin
      case (ph_r)
        PH_LO: begin
          acc_nxt = {(wide_r ? m[63:32] : 32'h0), m[31:0]};
          if (wide_r) begin
            ph_nxt = PH_CROSS1;
          end else begin
            run_nxt  = 1'b0;
            done_nxt = 1'b1;
          end
        end
        PH_CROSS1: begin
          acc_nxt[63:32] = acc_r[63:32] + m[31:0];
          ph_nxt = PH_CROSS2;
        end
        PH_CROSS2: begin
          acc_nxt[63:32] = acc_r[63:32] + m[31:0];
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
        default: begin
          run_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_LO;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
    end
  end

  // Operand capture and product register
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r    <= op_a;
      wide_r <= req.wide;
    end
    acc_r <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign prod     = acc_r;

  // A finished product comes only out of a running operation
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r)) else $error("product done without a running pass");

  // No new start while a pass is still running
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !run_r) else $error("multiplier started while busy");

endmodule

`default_nettype wire

// ===== rtl/murmur2_hash_64_core.sv =====
// Top level: streaming MurmurHash64A / 64B core with a sequencer around one shared multiplier.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    data_word, byte_count, first_word, last_word, message_length
//   out_ch   out  valid/ready    hash_value
//   cfg_ch   in   valid/ready    reg_index (0 hash_seed, 1 variant_select), write_data
//
// Every product passes through one 32x32 multiplier: a 64-bit product takes an issue step, three
// passes and a hand-back, a 32-bit lane product an issue step, its pass and a hand-back.
// A full 64A word takes the K1, K2 and H products (plus the seed on a first 64A item), a 64B word
// these per lane; final mix: FIN (64A) or F1 to F4 (64B). in_ch is ready only between items.
// Reset (rst_n low, synchronous) clears the state, the seed and the variant.
// A finished hash waits in the output register while the next item is taken; the last
// product of a later message's final mix waits until that register has been emptied.
`default_nettype none

module murmur2_hash_64_core
  import mh64_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mh64_in_if.sink   in_ch,
  mh64_out_if.source out_ch,
  mh64_cfg_if.sink  cfg_ch
);

  // Configuration registers
  logic [WORD_W-1:0] seed_r;
  logic              var_cfg_r;

  // Sequencer and hash state
  mh64_state_t       state_r, state_nxt;
  logic              issued_r, issued_nxt;
  logic              in_msg_r, in_msg_nxt;
  logic [WORD_W-1:0] h_r, h_nxt;
  logic [WORD_W-1:0] k_r, k_nxt;
  logic [WORD_W-1:0] fin_r, fin_nxt;

  // Latched item
  logic [WORD_W-1:0] data_r;
  logic [LEN_W-1:0]  len_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              last_r;
  logic              lane_r, lane_nxt;
  logic [LANE_W-1:0] rest_r, rest_nxt;
  logic [2:0]        rem_r, rem_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_hash_r, out_hash_nxt;
  logic              out_fill;

  // Multiplier link
  mh64_mul_req_t     mu_req;
  mh64_mul_rsp_t     mu_rsp;
  logic [WORD_W-1:0] mu_a;
  logic [WORD_W-1:0] mu_p;
  logic              gate;

  logic              in_acc;
  logic [CNT_W-1:0]  c_eff;
  logic [CNT_W-1:0]  c_less4;
  logic [LANE_W-1:0] lane_h, lane_k, p32, x32;

  // Mask of the low n bytes
  function automatic logic [WORD_W-1:0] byte_mask(input logic [2:0] n);
    logic [WORD_W-1:0] mk;
    mk = '0;
    for (int i = 0; i < 8; i++) begin
      mk[8*i +: 8] = (i < int'(n)) ? 8'hff : 8'h00;
    end
    return mk;
  endfunction

  // 64A body entry for a given byte count
  function automatic mh64_state_t next_a(input logic [CNT_W-1:0] c, input logic lst);
    mh64_state_t s;
    if (c == CNT_W'(8))       s = ST_A_K1;
    else if (c != '0)         s = ST_A_TAIL;
    else if (lst)             s = ST_A_FIN;
    else                      s = ST_IDLE;
    return s;
  endfunction

  // 64B second lane entry for the bytes left over
  function automatic mh64_state_t next_b(input logic [2:0] r, input logic lst);
    mh64_state_t s;
    if (r == 3'd4)            s = ST_B_K1;
    else if (r != 3'd0)       s = ST_B_TAIL;
    else if (lst)             s = ST_B_F1;
    else                      s = ST_IDLE;
    return s;
  endfunction

  mh64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mu_req),
    .op_a  (mu_a),
    .rsp   (mu_rsp),
    .prod  (mu_p)
  );

  // Handshakes
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;

  // Effective byte count: non-last items are full, oversize counts clamp to 8
  always_comb begin
    if (!in_ch.last_word || in_ch.byte_count > CNT_W'(8)) c_eff = CNT_W'(8);
    else                                                   c_eff = in_ch.byte_count;
    c_less4 = c_eff - CNT_W'(4);
  end

  // Sequencer: operand select, post-mix and next state
  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    in_msg_nxt = in_msg_r;
    h_nxt      = h_r;
    k_nxt      = k_r;
    fin_nxt    = fin_r;
    lane_nxt   = lane_r;
    rest_nxt   = rest_r;
    rem_nxt    = rem_r;
    out_fill   = 1'b0;
    out_hash_nxt = out_hash_r;
    mu_a       = '0;
    mu_req.wide = 1'b0;
    gate       = 1'b1;
    lane_h     = lane_r ? h_r[31:0] : h_r[63:32];
    lane_k     = lane_r ? rest_r : data_r[31:0];
    p32        = mu_p[31:0];
    x32        = p32 ^ (p32 >> SHIFT32);

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.first_word || in_msg_r)) begin
          in_msg_nxt = !in_ch.last_word;
          if (!var_cfg_r) begin
            state_nxt = in_ch.first_word ? ST_A_SEED : next_a(c_eff, in_ch.last_word);
          end else begin
            if (in_ch.first_word) begin
              h_nxt = {seed_r[31:0] ^ in_ch.message_length, seed_r[63:32]};
            end
            if (c_eff >= CNT_W'(4)) begin
              lane_nxt  = 1'b0;
              rest_nxt  = in_ch.data_word[63:32];
              rem_nxt   = c_less4[2:0];
              state_nxt = ST_B_K1;
            end else begin
              lane_nxt  = 1'b1;
              rest_nxt  = in_ch.data_word[31:0];
              rem_nxt   = c_eff[2:0];
              state_nxt = next_b(c_eff[2:0], in_ch.last_word);
            end
          end
        end
      end

      // 64A: seed, full block, tail and final mix
      ST_A_SEED: begin
        mu_a = {32'h0, len_r};
        mu_req.wide = 1'b1;
        if (mu_rsp.done) begin
          h_nxt     = seed_r ^ mu_p;
          state_nxt = next_a(cnt_r, last_r);
        end
      end
      ST_A_K1: begin
        mu_a = data_r;
        mu_req.wide = 1'b1;
        if (mu_rsp.done) begin
          k_nxt     = mu_p ^ (mu_p >> SHIFT64);
          state_nxt = ST_A_K2;
        end
      end
      ST_A_K2: begin
        mu_a = k_r;
        mu_req.wide = 1'b1;
        if (mu_rsp.done) begin
          h_nxt     = h_r ^ mu_p;
          state_nxt = ST_A_H;
        end
      end
      ST_A_H: begin
        mu_a = h_r;
        mu_req.wide = 1'b1;
        if (mu_rsp.done) begin
          h_nxt     = mu_p;
          state_nxt = last_r ? ST_A_FIN : ST_IDLE;
        end
      end
      ST_A_TAIL: begin
        mu_a = h_r ^ (data_r & byte_mask(cnt_r[2:0]));
        mu_req.wide = 1'b1;
        if (mu_rsp.done) begin
          h_nxt     = mu_p;
          state_nxt = last_r ? ST_A_FIN : ST_IDLE;
        end
      end
      ST_A_FIN: begin
        mu_a = h_r ^ (h_r >> SHIFT64);
        mu_req.wide = 1'b1;
        gate = !out_valid_r;
        if (mu_rsp.done) begin
          out_fill     = 1'b1;
          out_hash_nxt = mu_p ^ (mu_p >> SHIFT64);
          state_nxt    = ST_IDLE;
        end
      end

      // 64B: lane block, second lane tail and cross-mix
      ST_B_K1: begin
        mu_a = {32'h0, lane_k};
        if (mu_rsp.done) begin
          k_nxt     = {32'h0, x32};
          state_nxt = ST_B_K2;
        end
      end
      ST_B_K2: begin
        mu_a = {32'h0, k_r[31:0]};
        if (mu_rsp.done) begin
          k_nxt     = {32'h0, p32};
          state_nxt = ST_B_H;
        end
      end
      ST_B_H: begin
        mu_a = {32'h0, lane_h};
        if (mu_rsp.done) begin
          if (!lane_r) begin
            h_nxt[63:32] = p32 ^ k_r[31:0];
            lane_nxt     = 1'b1;
            state_nxt    = next_b(rem_r, last_r);
          end else begin
            h_nxt[31:0]  = p32 ^ k_r[31:0];
            state_nxt    = last_r ? ST_B_F1 : ST_IDLE;
          end
        end
      end
      ST_B_TAIL: begin
        mu_a = {32'h0, h_r[31:0] ^ (rest_r & 32'(byte_mask(rem_r)))};
        if (mu_rsp.done) begin
          h_nxt[31:0] = p32;
          state_nxt   = last_r ? ST_B_F1 : ST_IDLE;
        end
      end
      ST_B_F1: begin
        mu_a = {32'h0, h_r[63:32] ^ (h_r[31:0] >> XMIX_S1)};
        if (mu_rsp.done) begin
          fin_nxt   = {p32, h_r[31:0]};
          state_nxt = ST_B_F2;
        end
      end
      ST_B_F2: begin
        mu_a = {32'h0, fin_r[31:0] ^ (fin_r[63:32] >> XMIX_S2)};
        if (mu_rsp.done) begin
          fin_nxt[31:0] = p32;
          state_nxt     = ST_B_F3;
        end
      end
      ST_B_F3: begin
        mu_a = {32'h0, fin_r[63:32] ^ (fin_r[31:0] >> XMIX_S3)};
        if (mu_rsp.done) begin
          fin_nxt[63:32] = p32;
          state_nxt      = ST_B_F4;
        end
      end
      ST_B_F4: begin
        mu_a = {32'h0, fin_r[31:0] ^ (fin_r[63:32] >> XMIX_S4)};
        gate = !out_valid_r;
        if (mu_rsp.done) begin
          out_fill     = 1'b1;
          out_hash_nxt = {fin_r[63:32], p32};
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // One product in flight at a time
    mu_req.start = (state_r != ST_IDLE) && !issued_r && gate;
    if (mu_req.start)  issued_nxt = 1'b1;
    if (mu_rsp.done)   issued_nxt = 1'b0;
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_fill)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  // Control and hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      in_msg_r    <= 1'b0;
      h_r         <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
      var_cfg_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      in_msg_r    <= in_msg_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.reg_index)
          CFG_HASH_SEED: seed_r    <= cfg_ch.write_data;
          CFG_VARIANT:   var_cfg_r <= cfg_ch.write_data[0];
          default: ;
        endcase
      end
    end
  end

  // Item latch and working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_r <= in_ch.data_word;
      len_r  <= in_ch.message_length;
      cnt_r  <= c_eff;
      last_r <= in_ch.last_word;
    end
    k_r        <= k_nxt;
    fin_r      <= fin_nxt;
    lane_r     <= lane_nxt;
    rest_r     <= rest_nxt;
    rem_r      <= rem_nxt;
    out_hash_r <= out_hash_nxt;
  end

  // A product only comes back for an operation that was issued
  a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    mu_rsp.done |-> issued_r) else $error("multiplier result without request");

  // Nothing outstanding while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !issued_r) else $error("product in flight while idle");

  // A hash is written only from a final mix step and never over a waiting one
  a_fill_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_fill |-> ((state_r == ST_A_FIN || state_r == ST_B_F4) && !out_valid_r))
    else $error("output written out of turn");

  // The message is closed by the time its hash is written
  a_fill_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_fill |-> !in_msg_r) else $error("hash given while message still open");

endmodule

`default_nettype wire
